// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is active.
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds while reset is active.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/iswc_pkg.sv =====
package iswc_pkg;

    typedef enum logic [2:0] {
        PH_LEAD   = 3'd0,
        PH_DIGITS = 3'd1,
        PH_TRAIL  = 3'd2,
        PH_BAD    = 3'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_SHORT  = 2'd0,
        KIND_INT    = 2'd1,
        KIND_LONG   = 2'd2,
        KIND_DOUBLE = 2'd3
    } kind_t;

    localparam logic [15:0] CU_SPACE = 16'h0020;
    localparam logic [15:0] CU_MINUS = 16'h002D;
    localparam logic [15:0] CU_ZERO  = 16'h0030;
    localparam logic [15:0] CU_NINE  = 16'h0039;

    localparam logic [35:0] INT_LIMIT_POS   = 36'd2147483647;
    localparam logic [35:0] INT_LIMIT_NEG   = 36'd2147483648;
    localparam logic [31:0] SHORT_LIMIT_POS = 32'd32767;
    localparam logic [31:0] SHORT_LIMIT_NEG = 32'd32768;

    // Result handed from the scanner to the output buffer.
    typedef struct packed {
        logic  push;
        kind_t kind;
    } scan_res_t;

endpackage

// ===== rtl/core/iswc_scan.sv =====
module iswc_scan (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  logic [15:0]        code_unit,
    input  logic               end_of_text,
    input  logic               no_character,
    output iswc_pkg::scan_res_t res
);
    import iswc_pkg::*;

    phase_t      phase_reg, phase_next;
    logic        minus_reg, minus_next;
    logic [31:0] value_reg, value_next;
    logic        large_reg, large_next;

    logic        is_space;
    logic        is_digit;
    logic [3:0]  digit;
    logic [35:0] prod;
    logic [35:0] limit;
    logic        add;

    assign is_space = (code_unit == CU_SPACE);
    assign is_digit = (code_unit >= CU_ZERO) && (code_unit <= CU_NINE);
    assign digit    = 4'(code_unit - CU_ZERO);
    // value*10 + digit as two shifts and two adds
    assign prod     = ({4'b0, value_reg} << 3) + ({4'b0, value_reg} << 1)
                      + {32'b0, digit};

    always_comb
    begin
        phase_next = phase_reg;
        minus_next = minus_reg;
        add        = 1'b0;
        if (!no_character)
        begin
            unique case (phase_reg)
                PH_LEAD:
                begin
                    if (is_space)
                    begin
                        phase_next = PH_LEAD;
                    end
                    else if (code_unit == CU_MINUS)
                    begin
                        minus_next = 1'b1;
                        phase_next = PH_DIGITS;
                    end
                    else if (is_digit)
                    begin
                        add        = 1'b1;
                        phase_next = PH_DIGITS;
                    end
                    else
                    begin
                        phase_next = PH_BAD;
                    end
                end
                PH_DIGITS:
                begin
                    if (is_digit)
                    begin
                        add = 1'b1;
                    end
                    else if (is_space)
                    begin
                        phase_next = PH_TRAIL;
                    end
                    else
                    begin
                        phase_next = PH_BAD;
                    end
                end
                PH_TRAIL:
                begin
                    if (!is_space)
                    begin
                        phase_next = PH_BAD;
                    end
                end
                default:
                begin
                    phase_next = PH_BAD;
                end
            endcase
        end

        // limit uses the sign as it stands before this digit
        limit      = minus_reg ? INT_LIMIT_NEG : INT_LIMIT_POS;
        value_next = value_reg;
        large_next = large_reg;
        if (add)
        begin
            if (prod > limit)
            begin
                large_next = 1'b1;
            end
            value_next = (prod[35:32] != 4'b0) ? 32'hFFFF_FFFF : prod[31:0];
        end
    end

    always_comb
    begin
        res.push = take && end_of_text;
        if (phase_next != PH_LEAD && phase_next != PH_DIGITS && phase_next != PH_TRAIL)
        begin
            res.kind = KIND_DOUBLE;
        end
        else if (large_next)
        begin
            res.kind = KIND_LONG;
        end
        else if (value_next > (minus_next ? SHORT_LIMIT_NEG : SHORT_LIMIT_POS))
        begin
            res.kind = KIND_INT;
        end
        else
        begin
            res.kind = KIND_SHORT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEAD;
            minus_reg <= 1'b0;
            value_reg <= 32'b0;
            large_reg <= 1'b0;
        end
        else if (take)
        begin
            if (end_of_text)
            begin
                phase_reg <= PH_LEAD;
                minus_reg <= 1'b0;
                value_reg <= 32'b0;
                large_reg <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                minus_reg <= minus_next;
                value_reg <= value_next;
                large_reg <= large_next;
            end
        end
    end

endmodule

// ===== rtl/core/iswc_out_buf.sv =====
module iswc_out_buf (
    input  logic                clk,
    input  logic                rst_n,
    input  iswc_pkg::scan_res_t res,
    output logic                can_take,
    output logic                out_valid,
    input  logic                out_ready,
    output iswc_pkg::kind_t     out_kind
);
    import iswc_pkg::*;

    logic  main_valid_reg, main_valid_next;
    kind_t main_kind_reg, main_kind_next;
    logic  skid_valid_reg, skid_valid_next;
    kind_t skid_kind_reg, skid_kind_next;
    logic  pop;

    assign pop       = main_valid_reg && out_ready;
    assign can_take  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_kind  = main_kind_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_kind_next  = main_kind_reg;
        skid_valid_next = skid_valid_reg;
        skid_kind_next  = skid_kind_reg;
        if (skid_valid_reg)
        begin
            // no push possible while the skid holds a result
            if (pop)
            begin
                main_kind_next  = skid_kind_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (res.push)
        begin
            if (main_valid_reg && !pop)
            begin
                skid_valid_next = 1'b1;
                skid_kind_next  = res.kind;
            end
            else
            begin
                main_valid_next = 1'b1;
                main_kind_next  = res.kind;
            end
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_kind_reg <= main_kind_next;
        skid_kind_reg <= skid_kind_next;
    end

endmodule

// ===== rtl/core/integer_string_width_classifier.sv =====
// Integer string width classifier. Text arrives one UTF-16 code unit per
// transfer on the input channel; the item flagged end_of_text closes the
// text and yields one value_kind (0 short, 1 int, 2 long, 3 double), after
// which the scanner is back in its reset state. Items with no_character set
// carry no code unit; with end_of_text they close the text (alone: empty
// text, short). The block takes one item every clock while in_ready is high;
// the scan state and the saturating value*10+digit accumulator update at the
// transfer. The result goes to a two-entry output buffer (result register,
// or skid when that holds a waiting result), so input continues while a
// result waits; in_ready drops only when both entries are full.
module integer_string_width_classifier (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] code_unit,
    input  logic        end_of_text,
    input  logic        no_character,
    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  value_kind
);
    import iswc_pkg::*;

    scan_res_t res;
    kind_t     kind;
    logic      take;

    // a transfer on the input channel
    assign take = in_valid && in_ready;

    // leading spaces, minus, digits, trailing spaces; accumulator and flag
    iswc_scan u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .code_unit    (code_unit),
        .end_of_text  (end_of_text),
        .no_character (no_character),
        .res          (res)
    );

    // result register with skid entry
    iswc_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .can_take  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_kind  (kind)
    );

    assign value_kind = 2'(kind);

endmodule

// ===== rtl/core/iswc_checker.sv =====
`include "assert_macros.svh"

module iswc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [15:0] code_unit,
    input logic        end_of_text,
    input logic        no_character,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  value_kind
);

    // while reset stays low across consecutive clock edges the output is empty
    `ASSERT_ALWAYS(a_reset_empty, clk,
        (!rst_n ##1 !rst_n) |-> !out_valid,
        "out_valid during reset")
    `ASSERT_CLKD(a_out_hold, clk, rst_n,
        out_valid && !out_ready |=> out_valid && $stable(value_kind),
        "stalled result changed")
    `ASSERT_CLKD(a_stall_full, clk, rst_n,
        !in_ready |-> out_valid,
        "input stalled with empty output")
    `ASSERT_CLKD(a_no_phantom, clk, rst_n,
        in_valid && in_ready && !end_of_text && !out_valid |=> !out_valid,
        "result without closing item")
    `ASSERT_CLKD(a_close_result, clk, rst_n,
        in_valid && in_ready && end_of_text && !out_valid |=> out_valid,
        "closing item gave no result")

endmodule

bind integer_string_width_classifier iswc_checker u_iswc_checker (.*);
